// ----- design/qws_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the queue with search.
// Has no dependencies; every other file of the block imports it.
package qws_pkg;

  localparam int WORD_W    = 32;
  localparam int POS_W     = 5;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_SHOW = 2'd2,
    ACT_FIND = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_PUSH   = 2'd1,
    CELL_SHIFT  = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_WALK  = 2'd1,
    S_FLUSH = 2'd2
  } state_t;

  typedef struct packed {
    cell_op_t            op;
    logic [WORD_W-1:0]   push_word;
  } cell_ctl_t;

endpackage

// ----- design/qws_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the queue chain; holds the entry at a fixed position.
// Depends on qws_pkg.
module qws_cell import qws_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                          clk,
  input  cell_ctl_t                     ctl,
  input  logic [$clog2(DEPTH+1)-1:0]    count,
  input  logic [WORD_W-1:0]             head_word,
  input  logic [WORD_W-1:0]             next_word,
  output logic [WORD_W-1:0]             word
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (ctl.op)
      CELL_PUSH: begin
        if (count == MY_IDX) word_nxt = ctl.push_word;
      end
      CELL_SHIFT: begin
        word_nxt = next_word;
      end
      CELL_ROTATE: begin
        // The tail cell of the held entries takes the head, so a full walk
        // of count steps brings the queue back to where it started.
        if (count - CW'(1) == MY_IDX) word_nxt = head_word;
        else                          word_nxt = next_word;
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ----- design/qws_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the queue: request decode, walk over the chain, output register.
// Depends on qws_pkg.
module qws_ctrl import qws_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic signed [WORD_W-1:0]      in_operand,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic signed [WORD_W-1:0]      out_word,
  output logic [POS_W-1:0]              out_position,
  output logic                          out_last,
  input  logic [WORD_W-1:0]             head_word,
  output cell_ctl_t                     cell_ctl,
  output logic [$clog2(DEPTH+1)-1:0]    count
);

  localparam int CW = $clog2(DEPTH + 1);

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       step_r, step_nxt;
  act_t                act_r, act_nxt;
  logic [WORD_W-1:0]   key_r, key_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [WORD_W-1:0]   pend_word_r, pend_word_nxt;
  logic [POS_W-1:0]    pend_pos_r, pend_pos_nxt;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [POS_W-1:0]    out_pos_r;
  logic                out_last_r;

  logic                emit;
  status_t             e_status;
  logic [WORD_W-1:0]   e_word;
  logic [POS_W-1:0]    e_pos;
  logic                e_last;

  logic                out_free;
  logic                accept;
  logic                head_match;
  logic                at_end;
  logic                walk_go;
  logic [CW-1:0]       step_inc;
  logic [POS_W-1:0]    step_pos;
  act_t                in_act;

  assign in_act     = act_t'(in_action);
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == S_IDLE) && out_free);
  assign accept     = in_valid && !in_stall;
  assign head_match = (head_word == key_r);
  assign at_end     = (step_r == count_r - CW'(1));
  assign step_inc   = step_r + CW'(1);
  assign step_pos   = POS_W'(step_inc);
  // A search step only needs the output when it must push out an older match.
  assign walk_go    = (act_r == ACT_SHOW) ? out_free : (!(head_match && pend_v_r) || out_free);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && count_r != '0 && (in_act == ACT_SHOW || in_act == ACT_FIND))
          state_nxt = S_WALK;
      end
      S_WALK: begin
        if (walk_go && at_end) state_nxt = (act_r == ACT_SHOW) ? S_IDLE : S_FLUSH;
      end
      S_FLUSH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    emit               = 1'b0;
    e_status           = ST_OK;
    e_word             = '0;
    e_pos              = '0;
    e_last             = 1'b0;
    cell_ctl.op        = CELL_HOLD;
    cell_ctl.push_word = in_operand;
    count_nxt          = count_r;
    step_nxt           = step_r;
    act_nxt            = act_r;
    key_nxt            = key_r;
    pend_v_nxt         = pend_v_r;
    pend_word_nxt      = pend_word_r;
    pend_pos_nxt       = pend_pos_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_act == ACT_ENQ) begin
            emit   = 1'b1;
            e_last = 1'b1;
            if (count_r == CW'(DEPTH)) begin
              e_status = ST_FULL;
            end else begin
              e_word      = in_operand;
              cell_ctl.op = CELL_PUSH;
              count_nxt   = count_r + CW'(1);
            end
          end else if (count_r == '0) begin
            emit     = 1'b1;
            e_last   = 1'b1;
            e_status = ST_EMPTY;
          end else if (in_act == ACT_DEQ) begin
            emit        = 1'b1;
            e_last      = 1'b1;
            e_word      = head_word;
            cell_ctl.op = CELL_SHIFT;
            count_nxt   = count_r - CW'(1);
          end else begin
            act_nxt    = in_act;
            key_nxt    = in_operand;
            step_nxt   = '0;
            pend_v_nxt = 1'b0;
          end
        end
      end
      S_WALK: begin
        if (walk_go) begin
          cell_ctl.op = CELL_ROTATE;
          step_nxt    = step_inc;
          if (act_r == ACT_SHOW) begin
            emit   = 1'b1;
            e_word = head_word;
            e_pos  = step_pos;
            e_last = at_end;
          end else if (head_match) begin
            // Hold each match back until the next one shows whether it is final.
            if (pend_v_r) begin
              emit   = 1'b1;
              e_word = pend_word_r;
              e_pos  = pend_pos_r;
            end
            pend_v_nxt    = 1'b1;
            pend_word_nxt = head_word;
            pend_pos_nxt  = step_pos;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          emit   = 1'b1;
          e_last = 1'b1;
          if (pend_v_r) begin
            e_word = pend_word_r;
            e_pos  = pend_pos_r;
          end else begin
            e_status = ST_NOTFOUND;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    act_r       <= act_nxt;
    key_r       <= key_nxt;
    pend_word_r <= pend_word_nxt;
    pend_pos_r  <= pend_pos_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_word_r   <= e_word;
      out_pos_r    <= e_pos;
      out_last_r   <= e_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_word     = out_word_r;
  assign out_position = out_pos_r;
  assign out_last     = out_last_r;
  assign count        = count_r;

endmodule

// ----- design/queue_with_search_core.sv -----
// Queue with search: enqueue and dequeue give their single result in the cycle after the request.
// Display and search rotate the cell chain once per held entry after the accepting cycle; a step
// that must give a result waits while a stalled result holds the output, and search ends with a
// flush of its held match or a not-found result. One request is in work at a time.
// The output register lets a result wait under stall.
// rst_n is synchronous, active low, and empties the queue; stored words are not cleared.
`timescale 1ns / 1ps
// Depends on qws_pkg, qws_cell and qws_ctrl.
module queue_with_search_core import qws_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_action,
  input  logic signed [WORD_W-1:0]  in_operand,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic signed [WORD_W-1:0]  out_word,
  output logic [POS_W-1:0]          out_position,
  output logic                      out_last
);

  localparam int CW = $clog2(DEPTH + 1);

  cell_ctl_t          cell_ctl;
  logic [CW-1:0]      count;
  logic [WORD_W-1:0]  cell_word [DEPTH];

  qws_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_operand   (in_operand),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_word     (out_word),
    .out_position (out_position),
    .out_last     (out_last),
    .head_word    (cell_word[0]),
    .cell_ctl     (cell_ctl),
    .count        (count)
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == DEPTH - 1) begin : g_tail
      qws_cell #(.DEPTH(DEPTH), .IDX(k)) u_cell (
        .clk       (clk),
        .ctl       (cell_ctl),
        .count     (count),
        .head_word (cell_word[0]),
        .next_word (cell_word[k]),
        .word      (cell_word[k])
      );
    end else begin : g_body
      qws_cell #(.DEPTH(DEPTH), .IDX(k)) u_cell (
        .clk       (clk),
        .ctl       (cell_ctl),
        .count     (count),
        .head_word (cell_word[0]),
        .next_word (cell_word[k+1]),
        .word      (cell_word[k])
      );
    end
  end

endmodule

// ----- design/qws_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the queue with search, bound to the top level.
// Depends on qws_pkg and queue_with_search_core.
module qws_checker import qws_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [1:0]                in_action,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [1:0]                out_status,
  input logic [WORD_W-1:0]         out_word,
  input logic [POS_W-1:0]          out_position,
  input logic                      out_last
);

  // An enqueue request answers in the very next cycle with a single result.
  a_enq_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ACT_ENQ |=>
      out_valid && out_last && (out_status == ST_OK || out_status == ST_FULL))
    else $error("enqueue result missing or malformed");

  // Every error result ends its request and carries no word or position.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_last && out_word == '0 && out_position == '0)
    else $error("error result not clean");

  // While a request still has results to give, no new request is taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("request taken during multi-result answer");

  // A held result stays put under stall.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind queue_with_search_core qws_checker u_qws_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_action    (in_action),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_status   (out_status),
  .out_word     (out_word),
  .out_position (out_position),
  .out_last     (out_last)
);

// ----- verif/tb_queue_with_search_core.sv -----
`timescale 1ns / 1ps
// Testbench for queue_with_search_core: directed and random requests are checked against
// a ring-queue predictor kept in the bench. Depends on qws_pkg and the design files.
module tb_queue_with_search_core;
  import qws_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] word;
    logic [POS_W-1:0]  position;
    logic              last;
  } result_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_action  = ACT_ENQ;
  logic signed [WORD_W-1:0] in_operand = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic [1:0]               out_status;
  logic signed [WORD_W-1:0] out_word;
  logic [POS_W-1:0]         out_position;
  logic                     out_last;

  // Predicted queue contents and the results still owed by the block.
  logic [WORD_W-1:0] model_ring [QDEPTH];
  int unsigned       model_head = 0;
  int unsigned       model_fill = 0;
  result_t           awaited_results [$];

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned error_count = 0;

  queue_with_search_core #(.DEPTH(QDEPTH)) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_operand  (in_operand),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_word    (out_word),
    .out_position(out_position),
    .out_last    (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic owe_result(input status_t st, input logic [WORD_W-1:0] w,
                            input int unsigned pos, input logic fin);
    result_t r;
    r.status   = st;
    r.word     = w;
    r.position = POS_W'(pos);
    r.last     = fin;
    awaited_results.push_back(r);
  endtask

  // Updates the predicted queue for one accepted request and records its results.
  task automatic apply_queue_action(input act_t act, input logic [WORD_W-1:0] opnd);
    int unsigned k;
    int unsigned hits;
    int unsigned seen;
    logic [WORD_W-1:0] w;
    hits = 0;
    seen = 0;
    if (act == ACT_ENQ) begin
      if (model_fill >= QDEPTH) begin
        owe_result(ST_FULL, '0, 0, 1'b1);
      end else begin
        model_ring[(model_head + model_fill) % QDEPTH] = opnd;
        model_fill++;
        owe_result(ST_OK, opnd, 0, 1'b1);
      end
    end else if (model_fill == 0) begin
      owe_result(ST_EMPTY, '0, 0, 1'b1);
    end else if (act == ACT_DEQ) begin
      w = model_ring[model_head];
      model_head = (model_head + 1) % QDEPTH;
      model_fill--;
      owe_result(ST_OK, w, 0, 1'b1);
    end else if (act == ACT_SHOW) begin
      for (k = 0; k < model_fill; k++) begin
        owe_result(ST_OK, model_ring[(model_head + k) % QDEPTH], k + 1, k + 1 == model_fill);
      end
    end else begin
      for (k = 0; k < model_fill; k++) begin
        if (model_ring[(model_head + k) % QDEPTH] == opnd) hits++;
      end
      if (hits == 0) begin
        owe_result(ST_NOTFOUND, '0, 0, 1'b1);
      end
      for (k = 0; k < model_fill; k++) begin
        if (model_ring[(model_head + k) % QDEPTH] == opnd) begin
          seen++;
          owe_result(ST_OK, opnd, k + 1, seen == hits);
        end
      end
    end
  endtask

  // Holds the request until it is accepted; valid stays high for a back-to-back request.
  task automatic send_request(input act_t act, input logic [WORD_W-1:0] opnd);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_operand <= opnd;
    do @(posedge clk); while (in_stall);
    apply_queue_action(act, opnd);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // A small pool of values makes duplicates, so searches find several matches.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0:          return 32'h8000_0000;
      1:          return 32'h7FFF_FFFF;
      2:          return '1;
      3, 4, 5, 6: return WORD_W'($urandom_range(7));
      default:    return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d word %0h position %0d last %0b",
               out_status, out_word, out_position, out_last);
        error_count++;
      end else begin
        exp_r = awaited_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_status);
          error_count++;
        end
        if (out_word !== exp_r.word) begin
          $error("word: expected %0h, got %0h", exp_r.word, out_word);
          error_count++;
        end
        if (out_position !== exp_r.position) begin
          $error("position: expected %0d, got %0d", exp_r.position, out_position);
          error_count++;
        end
        if (out_last !== exp_r.last) begin
          $error("last: expected %0b, got %0b", exp_r.last, out_last);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_queue();
    send_request(ACT_DEQ, 32'h1234_5678);
    send_request(ACT_SHOW, '0);
    send_request(ACT_FIND, '0);
    wait_for_results();
  endtask

  task automatic test_extreme_words();
    send_request(ACT_ENQ, 32'h7FFF_FFFF);
    send_request(ACT_ENQ, 32'h8000_0000);
    send_request(ACT_ENQ, 32'hFFFF_FFFF);
    send_request(ACT_ENQ, 32'h0000_0000);
    send_request(ACT_ENQ, 32'd5);
    send_request(ACT_ENQ, 32'd5);
    send_request(ACT_SHOW, 32'hDEAD_BEEF);
    send_request(ACT_FIND, 32'd5);
    send_request(ACT_FIND, 32'h8000_0000);
    send_request(ACT_FIND, 32'd1234);
    wait_for_results();
  endtask

  task automatic test_full_queue();
    while (model_fill < QDEPTH) send_request(ACT_ENQ, pick_word());
    send_request(ACT_ENQ, 32'h5555_AAAA);
    send_request(ACT_SHOW, '0);
    wait_for_results();
  endtask

  // Alternates stretches that fill the queue with stretches that drain it.
  task automatic test_random_traffic(input int unsigned count, input int unsigned idle,
                                     input int unsigned stall);
    int unsigned n;
    int unsigned roll;
    int unsigned enq_w;
    int unsigned deq_w;
    act_t act;
    logic [WORD_W-1:0] opnd;
    idle_pct  = idle;
    stall_pct = stall;
    for (n = 0; n < count; n++) begin
      enq_w = ((n / 20) % 2 == 0) ? 65 : 15;
      deq_w = ((n / 20) % 2 == 0) ? 10 : 55;
      roll  = $urandom_range(99);
      if (roll < enq_w) act = ACT_ENQ;
      else if (roll < enq_w + deq_w) act = ACT_DEQ;
      else if (roll < enq_w + deq_w + (100 - enq_w - deq_w) / 3) act = ACT_SHOW;
      else act = ACT_FIND;
      opnd = pick_word();
      if (act == ACT_FIND && model_fill != 0 && $urandom_range(99) < 60) begin
        opnd = model_ring[(model_head + $urandom_range(model_fill - 1)) % QDEPTH];
      end
      send_request(act, opnd);
    end
    wait_for_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_extreme_words();
    test_full_queue();
    test_random_traffic(40, 0, 0);
    test_random_traffic(40, 61, 0);
    test_random_traffic(40, 0, 61);
    test_random_traffic(40, 11, 11);
    idle_pct  = 0;
    stall_pct = 0;
    repeat (QDEPTH + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS queue_with_search_core");
    end else begin
      $display("FAIL queue_with_search_core");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL queue_with_search_core");
    $finish;
  end

endmodule

// ----- files.f -----
design/qws_pkg.sv
design/qws_cell.sv
design/qws_ctrl.sv
design/queue_with_search_core.sv
design/qws_checker.sv
verif/tb_queue_with_search_core.sv
